FILE: hw/rtl/atan2_polynomial_fixed_core_assert.svh
// Assertion macros for the checker file.
`ifndef ATAN2_POLYNOMIAL_FIXED_CORE_ASSERT_SVH
`define ATAN2_POLYNOMIAL_FIXED_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ATP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/atp_pkg.sv
`default_nettype none
package atp_pkg;

  localparam int COORD_W = 32;
  localparam int MAG_W   = 32;
  localparam int QUOT_W  = 31;
  localparam int ACC_W   = 32;
  localparam int ANGLE_W = 27;
  localparam int FRAC_W  = 30;
  localparam int OUT_SHIFT = 4;
  localparam int HORNER_STEPS = 5;

  localparam logic signed [ACC_W-1:0] POLY_C5 = -32'sd2303695;
  localparam logic signed [ACC_W-1:0] POLY_COEF [HORNER_STEPS] = '{
    32'sd9822374, -32'sd20718705, 32'sd33432481, -32'sd56905886, 32'sd170890572
  };

  localparam logic signed [ACC_W-1:0] QUARTER_TURN = 32'sh1000_0000;
  localparam logic signed [ACC_W-1:0] HALF_TURN    = 32'sh2000_0000;

  typedef struct packed {
    logic swapped;
    logic x_neg;
    logic y_neg;
    logic zero;
  } flags_t;

endpackage
`default_nettype wire

FILE: hw/rtl/atp_divider.sv
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, quotient = (small << 30) / big.
// The caller guarantees small <= big.
module atp_divider (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [atp_pkg::MAG_W-1:0]  in_small,
  input  wire logic [atp_pkg::MAG_W-1:0]  in_big,
  input  wire atp_pkg::flags_t            in_flags,
  output logic                            out_valid,
  output logic [atp_pkg::QUOT_W-1:0]      out_quot,
  output atp_pkg::flags_t                 out_flags
);

  localparam int Steps = atp_pkg::QUOT_W;
  localparam int MagW  = atp_pkg::MAG_W;

  logic [Steps-1:0]        vld_r;
  logic [MagW-1:0]         rem_r  [Steps];
  logic [MagW-1:0]         big_r  [Steps];
  logic [Steps-1:0]        quot_r [Steps];
  atp_pkg::flags_t         flg_r  [Steps];

  genvar k;
  generate
    for (k = 0; k < Steps; k++) begin : g_step
      logic [MagW:0]    rem_in;
      logic [MagW-1:0]  big_in;
      logic [Steps-1:0] quot_in;
      logic             vld_in;
      atp_pkg::flags_t  flg_in;
      logic             take;
      logic [MagW:0]    diff;

      if (k == 0) begin : g_first
        assign rem_in  = {1'b0, in_small};
        assign big_in  = in_big;
        assign quot_in = '0;
        assign vld_in  = in_valid;
        assign flg_in  = in_flags;
      end else begin : g_rest
        assign rem_in  = {rem_r[k-1], 1'b0};
        assign big_in  = big_r[k-1];
        assign quot_in = quot_r[k-1];
        assign vld_in  = vld_r[k-1];
        assign flg_in  = flg_r[k-1];
      end

      assign take = (rem_in >= {1'b0, big_in});
      assign diff = rem_in - {1'b0, big_in};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= take ? diff[MagW-1:0] : rem_in[MagW-1:0];
          big_r[k]  <= big_in;
          quot_r[k] <= {quot_in[Steps-2:0], take};
          flg_r[k]  <= flg_in;
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[Steps-1];
  assign out_quot  = quot_r[Steps-1];
  assign out_flags = flg_r[Steps-1];

endmodule
`default_nettype wire

FILE: hw/rtl/atp_poly.sv
`default_nettype none
// Square of the ratio, five Horner steps and the final product with the ratio,
// one multiplier per stage.
module atp_poly (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic [atp_pkg::QUOT_W-1:0]        in_ratio,
  input  wire atp_pkg::flags_t                   in_flags,
  output logic                                   out_valid,
  output logic signed [atp_pkg::ACC_W-1:0]       out_ang,
  output atp_pkg::flags_t                        out_flags
);

  localparam int QW = atp_pkg::QUOT_W;
  localparam int AW = atp_pkg::ACC_W;
  localparam int FW = atp_pkg::FRAC_W;
  localparam int NH = atp_pkg::HORNER_STEPS;

  // Square stage.
  logic                sq_vld_r;
  logic [QW-1:0]       sq_s_r;
  logic [QW-1:0]       sq_ratio_r;
  atp_pkg::flags_t     sq_flg_r;
  logic [2*QW-1:0]     sq_prod;

  assign sq_prod = in_ratio * in_ratio;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (en) begin
      sq_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_s_r     <= sq_prod[FW+QW-1:FW];
      sq_ratio_r <= in_ratio;
      sq_flg_r   <= in_flags;
    end
  end

  // Horner stages.
  logic [NH-1:0]          h_vld_r;
  logic signed [AW-1:0]   h_acc_r   [NH];
  logic [QW-1:0]          h_s_r     [NH];
  logic [QW-1:0]          h_ratio_r [NH];
  atp_pkg::flags_t        h_flg_r   [NH];

  genvar j;
  generate
    for (j = 0; j < NH; j++) begin : g_horner
      logic signed [AW-1:0]   acc_in;
      logic [QW-1:0]          s_in;
      logic [QW-1:0]          ratio_in;
      logic                   vld_in;
      atp_pkg::flags_t        flg_in;
      logic signed [2*AW-1:0] prod;

      if (j == 0) begin : g_first
        assign acc_in   = atp_pkg::POLY_C5;
        assign s_in     = sq_s_r;
        assign ratio_in = sq_ratio_r;
        assign vld_in   = sq_vld_r;
        assign flg_in   = sq_flg_r;
      end else begin : g_rest
        assign acc_in   = h_acc_r[j-1];
        assign s_in     = h_s_r[j-1];
        assign ratio_in = h_ratio_r[j-1];
        assign vld_in   = h_vld_r[j-1];
        assign flg_in   = h_flg_r[j-1];
      end

      assign prod = acc_in * $signed({1'b0, s_in});

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          h_vld_r[j] <= 1'b0;
        end else if (en) begin
          h_vld_r[j] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          h_acc_r[j]   <= $signed(prod[FW+AW-1:FW]) + atp_pkg::POLY_COEF[j];
          h_s_r[j]     <= s_in;
          h_ratio_r[j] <= ratio_in;
          h_flg_r[j]   <= flg_in;
        end
      end
    end
  endgenerate

  // Final product with the ratio; the arithmetic part-select is a floor shift.
  logic                   fin_vld_r;
  logic signed [AW-1:0]   fin_ang_r;
  atp_pkg::flags_t        fin_flg_r;
  logic signed [2*AW-1:0] fin_prod;

  assign fin_prod = h_acc_r[NH-1] * $signed({1'b0, h_ratio_r[NH-1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= h_vld_r[NH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_ang_r <= $signed(fin_prod[FW+AW-1:FW]);
      fin_flg_r <= h_flg_r[NH-1];
    end
  end

  assign out_valid = fin_vld_r;
  assign out_ang   = fin_ang_r;
  assign out_flags = fin_flg_r;

endmodule
`default_nettype wire

FILE: hw/rtl/atan2_polynomial_fixed_core.sv
`default_nettype none
// Channel   Ports                              Direction
// input     in_valid in_ready in_y_coord/x     request in
// result    out_valid out_ready out_angle      request out
//
// The pipeline holds a magnitude and octant register, 31 divider stages
// (one quotient bit each), one square, five Horner steps, one final product
// and one fold stage that drives the output register.
// A new request is taken every cycle; the whole pipeline advances together
// and holds while the output register is full and out_ready is low.
// Synchronous active-low reset clears the valid bits only.
module atan2_polynomial_fixed_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [atp_pkg::COORD_W-1:0]  in_y_coord,
  input  wire logic signed [atp_pkg::COORD_W-1:0]  in_x_coord,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [atp_pkg::ANGLE_W-1:0]       out_angle
);

  localparam int MagW = atp_pkg::MAG_W;
  localparam int AW   = atp_pkg::ACC_W;

  logic en;
  logic out_valid_r;
  logic signed [atp_pkg::ANGLE_W-1:0] angle_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Magnitudes and octant.
  logic [MagW-1:0] ay, ax;
  logic            swap;
  logic            pre_vld_r;
  logic [MagW-1:0] pre_small_r, pre_big_r;
  atp_pkg::flags_t pre_flg_r;

  assign ay   = in_y_coord[MagW-1] ? (~in_y_coord + 1'b1) : in_y_coord;
  assign ax   = in_x_coord[MagW-1] ? (~in_x_coord + 1'b1) : in_x_coord;
  assign swap = !(ax > ay);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (en) begin
      pre_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_small_r       <= swap ? ax : ay;
      pre_big_r         <= swap ? ay : ax;
      pre_flg_r.swapped <= swap;
      pre_flg_r.x_neg   <= in_x_coord[MagW-1];
      pre_flg_r.y_neg   <= in_y_coord[MagW-1];
      pre_flg_r.zero    <= (ax == '0) && (ay == '0);
    end
  end

  logic                        div_vld;
  logic [atp_pkg::QUOT_W-1:0]  div_quot;
  atp_pkg::flags_t             div_flg;

  atp_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pre_vld_r),
    .in_small  (pre_small_r),
    .in_big    (pre_big_r),
    .in_flags  (pre_flg_r),
    .out_valid (div_vld),
    .out_quot  (div_quot),
    .out_flags (div_flg)
  );

  logic                 poly_vld;
  logic signed [AW-1:0] poly_ang;
  atp_pkg::flags_t      poly_flg;

  atp_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_vld),
    .in_ratio  (div_quot),
    .in_flags  (div_flg),
    .out_valid (poly_vld),
    .out_ang   (poly_ang),
    .out_flags (poly_flg)
  );

  // Octant fold, then drop to 2^26 units per turn.
  logic signed [AW-1:0] f_swap, f_x, f_y;

  assign f_swap = poly_flg.swapped ? (atp_pkg::QUARTER_TURN - poly_ang) : poly_ang;
  assign f_x    = poly_flg.x_neg ? (atp_pkg::HALF_TURN - f_swap) : f_swap;
  assign f_y    = poly_flg.y_neg ? -f_x : f_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= poly_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= poly_flg.zero ? '0 :
                 f_y[atp_pkg::ANGLE_W+atp_pkg::OUT_SHIFT-1:atp_pkg::OUT_SHIFT];
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle = angle_r;

endmodule
`default_nettype wire

FILE: hw/rtl/atp_checker.sv
`default_nettype none
`include "atan2_polynomial_fixed_core_assert.svh"
module atp_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [atp_pkg::ANGLE_W-1:0]   out_angle
);

  logic stalled;
  logic ang_ok;

  assign stalled = out_valid && !out_ready;
  assign ang_ok  = (out_angle >= -27'sd33554432) && (out_angle <= 27'sd33554432);

  // A result waiting for the sink must hold.
  `ATP_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_valid && $stable(out_angle), "result moved")
  // The angle never leaves a half turn either way.
  `ATP_ASSERT_SAME(a_range, clk, rst_n, out_valid, ang_ok, "angle out of range")
  // An empty output register never blocks new requests.
  `ATP_ASSERT_SAME(a_ready_empty, clk, rst_n, !out_valid, in_ready, "input blocked while empty")
  // A draining sink keeps the pipeline moving.
  `ATP_ASSERT_SAME(a_ready_drain, clk, rst_n, out_ready, in_ready, "blocked with sink ready")

endmodule

bind atan2_polynomial_fixed_core atp_checker u_atp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_angle (out_angle)
);
`default_nettype wire
